// ===== rtl/core/tsb_pkg.sv =====
// Shared types and constants for the TSO store buffer.
package tsb_pkg;

    localparam int DEF_BUFFER_DEPTH   = 16;
    localparam int DEF_MEMORY_WORDS   = 256;
    localparam int DEF_REGISTER_COUNT = 6;

    localparam int ADDR_W    = 8;
    localparam int REG_IDX_W = 3;
    localparam int DATA_W    = 32;
    localparam int ADDR_SPAN = 1 << ADDR_W;

    typedef enum logic [1:0] {
        CMD_STORE = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_IMM   = 2'd2,
        CMD_FLUSH = 2'd3
    } cmd_t;

    localparam logic KIND_COMMIT = 1'b0;
    localparam logic KIND_LOAD   = 1'b1;

    // one buffered store: target address and source register
    typedef struct packed {
        logic [ADDR_W-1:0]    addr;
        logic [REG_IDX_W-1:0] src;
    } entry_t;

    // data memory write controls
    typedef struct packed {
        logic data_we;
        logic pend_we;
        logic pend_val;
    } dmem_wr_t;

    // register file controls
    typedef struct packed {
        logic we;
        logic pend_set;
        logic pend_clr;
    } regs_ctl_t;

endpackage

// ===== rtl/core/tso_store_buffer_top.sv =====
// TSO store buffer core: request decode, drain sequencer and result register.
// Requests: one at a time; req_stall holds until the previous one is through. A
//   load passes S_LOAD_RD and S_LOAD_CHK before its result is registered.
// Drain: one entry per cycle when the output is not stalled; a flush, a full-buffer
//   store or a conflicting load first drains every entry, then the store is pushed or the load reread.
// Reset: asynchronous, active low; memory swept word by word after reset, requests stall.
module tso_store_buffer_top #(
    parameter int BUFFER_DEPTH   = tsb_pkg::DEF_BUFFER_DEPTH,
    parameter int MEMORY_WORDS   = tsb_pkg::DEF_MEMORY_WORDS,
    parameter int REGISTER_COUNT = tsb_pkg::DEF_REGISTER_COUNT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // request channel
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic [1:0]                          cmd,
    input  logic [tsb_pkg::ADDR_W-1:0]          mem_address,
    input  logic [tsb_pkg::REG_IDX_W-1:0]       reg_index,
    input  logic signed [tsb_pkg::DATA_W-1:0]   imm_value,
    // result channel
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic                                kind,
    output logic [tsb_pkg::ADDR_W-1:0]          out_address,
    output logic [tsb_pkg::REG_IDX_W-1:0]       out_reg,
    output logic signed [tsb_pkg::DATA_W-1:0]   out_value,
    output logic                                last
);

    localparam int SLOT_W = (MEMORY_WORDS > 1) ? $clog2(MEMORY_WORDS) : 1;
    localparam int CW     = $clog2(BUFFER_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_LOAD_RD,
        S_LOAD_CHK,
        S_DRAIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    // captured request
    logic [1:0]                     cmd_reg;
    logic [tsb_pkg::ADDR_W-1:0]     addr_reg;
    logic [tsb_pkg::REG_IDX_W-1:0]  reg_reg;

    // result register
    logic                           rsp_valid_reg;
    logic                           rsp_valid_next;
    logic                           kind_reg;
    logic                           kind_next;
    logic [tsb_pkg::ADDR_W-1:0]     addr_out_reg;
    logic [tsb_pkg::ADDR_W-1:0]     addr_out_next;
    logic [tsb_pkg::REG_IDX_W-1:0]  reg_out_reg;
    logic [tsb_pkg::REG_IDX_W-1:0]  reg_out_next;
    logic [tsb_pkg::DATA_W-1:0]     value_reg;
    logic [tsb_pkg::DATA_W-1:0]     value_next;
    logic                           last_reg;
    logic                           last_next;

    logic accept;
    logic out_free;

    // address folding table: byte address -> memory slot
    logic [SLOT_W-1:0] slot_tab [tsb_pkg::ADDR_SPAN];

    for (genvar i = 0; i < tsb_pkg::ADDR_SPAN; i++)
    begin : g_slot
        assign slot_tab[i] = SLOT_W'(i % MEMORY_WORDS);
    end

    logic [SLOT_W-1:0] slot_cur;
    logic [SLOT_W-1:0] slot_head;

    // store queue
    logic             q_push;
    logic             q_pop;
    tsb_pkg::entry_t  q_push_entry;
    tsb_pkg::entry_t  q_head;
    logic [CW-1:0]    q_count;
    logic             q_full;

    // data memory
    logic                       dm_busy;
    logic [tsb_pkg::DATA_W-1:0] dm_rd_data;
    logic                       dm_rd_pend;
    tsb_pkg::dmem_wr_t          dm_wr;
    logic [SLOT_W-1:0]          dm_wr_addr;
    logic [tsb_pkg::DATA_W-1:0] dm_wr_data;

    // register file
    tsb_pkg::regs_ctl_t             rf_ctl;
    logic [tsb_pkg::REG_IDX_W-1:0]  rf_wr_idx;
    logic [tsb_pkg::DATA_W-1:0]     rf_wr_data;
    logic [tsb_pkg::REG_IDX_W-1:0]  rf_pend_idx;
    logic [tsb_pkg::DATA_W-1:0]     rf_rd_data;
    logic                           rf_chk_pend;
    logic                           load_conflict;

    assign slot_cur  = slot_tab[addr_reg];
    assign slot_head = slot_tab[q_head.addr];

    assign q_push_entry.addr = addr_reg;
    assign q_push_entry.src  = reg_reg;
    assign q_full            = (q_count == CW'(BUFFER_DEPTH));

    assign req_stall = (state_reg != S_IDLE) || dm_busy;
    assign accept    = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    // a load must wait for the buffer when its word or register is in flight
    assign load_conflict = (dm_rd_pend || rf_chk_pend) && (q_count != '0);

    tsb_queue #(
        .DEPTH (BUFFER_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .pop        (q_pop),
        .head_entry (q_head),
        .count      (q_count)
    );

    tsb_dmem #(
        .WORDS (MEMORY_WORDS)
    ) u_dmem (
        .clk     (clk),
        .rst_n   (rst_n),
        .busy    (dm_busy),
        .rd_addr (slot_cur),
        .rd_data (dm_rd_data),
        .rd_pend (dm_rd_pend),
        .wr      (dm_wr),
        .wr_addr (dm_wr_addr),
        .wr_data (dm_wr_data)
    );

    tsb_regs #(
        .COUNT (REGISTER_COUNT)
    ) u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (rf_ctl),
        .wr_idx   (rf_wr_idx),
        .wr_data  (rf_wr_data),
        .pend_idx (rf_pend_idx),
        .rd_idx   (q_head.src),
        .rd_data  (rf_rd_data),
        .chk_idx  (reg_reg),
        .chk_pend (rf_chk_pend)
    );

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        kind_next      = kind_reg;
        addr_out_next  = addr_out_reg;
        reg_out_next   = reg_out_reg;
        value_next     = value_reg;
        last_next      = last_reg;

        q_push      = 1'b0;
        q_pop       = 1'b0;
        dm_wr       = '0;
        dm_wr_addr  = slot_cur;
        dm_wr_data  = rf_rd_data;
        rf_ctl      = '0;
        rf_wr_idx   = reg_index;
        rf_wr_data  = imm_value;
        rf_pend_idx = reg_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd)
                        tsb_pkg::CMD_STORE:
                        begin
                            state_next = q_full ? S_DRAIN : S_PUSH;
                        end
                        tsb_pkg::CMD_LOAD:
                        begin
                            state_next = S_LOAD_RD;
                        end
                        tsb_pkg::CMD_IMM:
                        begin
                            rf_ctl.we = 1'b1;
                        end
                        tsb_pkg::CMD_FLUSH:
                        begin
                            if (q_count != '0)
                            begin
                                state_next = S_DRAIN;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_PUSH:
            begin
                // queue the store, mark its word and source register
                q_push          = 1'b1;
                dm_wr.pend_we   = 1'b1;
                dm_wr.pend_val  = 1'b1;
                rf_ctl.pend_set = 1'b1;
                state_next      = S_IDLE;
            end

            S_LOAD_RD:
            begin
                state_next = S_LOAD_CHK;
            end

            S_LOAD_CHK:
            begin
                if (load_conflict)
                begin
                    state_next = S_DRAIN;
                end
                else if (out_free)
                begin
                    rf_ctl.we       = 1'b1;
                    rf_ctl.pend_clr = 1'b1;
                    rf_wr_idx       = reg_reg;
                    rf_wr_data      = dm_rd_data;
                    dm_wr.pend_we   = 1'b1;
                    dm_wr.pend_val  = 1'b0;
                    rsp_valid_next  = 1'b1;
                    kind_next       = tsb_pkg::KIND_LOAD;
                    addr_out_next   = addr_reg;
                    reg_out_next    = reg_reg;
                    value_next      = dm_rd_data;
                    last_next       = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            S_DRAIN:
            begin
                if (out_free)
                begin
                    // commit head: register value as of now goes to memory
                    q_pop           = 1'b1;
                    dm_wr.data_we   = 1'b1;
                    dm_wr.pend_we   = 1'b1;
                    dm_wr.pend_val  = 1'b0;
                    dm_wr_addr      = slot_head;
                    dm_wr_data      = rf_rd_data;
                    rf_ctl.pend_clr = 1'b1;
                    rf_pend_idx     = q_head.src;
                    rsp_valid_next  = 1'b1;
                    kind_next       = tsb_pkg::KIND_COMMIT;
                    addr_out_next   = q_head.addr;
                    reg_out_next    = q_head.src;
                    value_next      = rf_rd_data;
                    last_next       = (q_count == CW'(1)) && (cmd_reg != tsb_pkg::CMD_LOAD);
                    if (q_count == CW'(1))
                    begin
                        if (cmd_reg == tsb_pkg::CMD_LOAD)
                        begin
                            state_next = S_LOAD_RD;
                        end
                        else if (cmd_reg == tsb_pkg::CMD_STORE)
                        begin
                            state_next = S_PUSH;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd;
            addr_reg <= mem_address;
            reg_reg  <= reg_index;
        end
        kind_reg     <= kind_next;
        addr_out_reg <= addr_out_next;
        reg_out_reg  <= reg_out_next;
        value_reg    <= value_next;
        last_reg     <= last_next;
    end

    assign rsp_valid   = rsp_valid_reg;
    assign kind        = kind_reg;
    assign out_address = addr_out_reg;
    assign out_reg     = reg_out_reg;
    assign out_value   = value_reg;
    assign last        = last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= CW'(BUFFER_DEPTH))
        else $error("store buffer count beyond depth");

    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN) |-> (q_count != '0))
        else $error("drain with empty buffer");

    a_load_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (kind_reg == tsb_pkg::KIND_LOAD)) |-> last_reg)
        else $error("load result not marked last");

    a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        dm_busy |-> !rsp_valid_reg)
        else $error("result during memory clear");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUSH) |-> !q_full)
        else $error("push into full buffer");
`endif

endmodule

// ===== rtl/core/tsb_queue.sv =====
// Store buffer FIFO: entry memory with head pointer and fill count.
module tsb_queue #(
    parameter int DEPTH = tsb_pkg::DEF_BUFFER_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  tsb_pkg::entry_t              push_entry,
    input  logic                         pop,
    output tsb_pkg::entry_t              head_entry,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int HW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tsb_pkg::entry_t mem [DEPTH];
    tsb_pkg::entry_t rd_reg;

    logic [HW-1:0] head_reg;
    logic [HW-1:0] head_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW:0]   tail_sum;
    logic [HW-1:0] tail;

    always_comb
    begin
        tail_sum = (CW+1)'(head_reg) + (CW+1)'(count_reg);
        if (tail_sum >= (CW+1)'(DEPTH))
        begin
            tail_sum = tail_sum - (CW+1)'(DEPTH);
        end
        tail = tail_sum[HW-1:0];
    end

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (pop)
        begin
            head_next  = (head_reg == HW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
            count_next = count_next - 1'b1;
        end
        if (push)
        begin
            count_next = count_next + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // read port follows the next head; forward a push into the same slot
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[tail] <= push_entry;
        end
        if (push && (tail == head_next))
        begin
            rd_reg <= push_entry;
        end
        else
        begin
            rd_reg <= mem[head_next];
        end
    end

    assign head_entry = rd_reg;
    assign count      = count_reg;

endmodule

// ===== rtl/core/tsb_dmem.sv =====
// Data memory with per-word pending flags and a clearing sweep after reset.
module tsb_dmem #(
    parameter int WORDS = tsb_pkg::DEF_MEMORY_WORDS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    output logic                                  busy,
    input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] rd_addr,
    output logic [tsb_pkg::DATA_W-1:0]            rd_data,
    output logic                                  rd_pend,
    input  tsb_pkg::dmem_wr_t                     wr,
    input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] wr_addr,
    input  logic [tsb_pkg::DATA_W-1:0]            wr_data
);

    localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;

    logic [tsb_pkg::DATA_W-1:0] data_mem [WORDS];
    logic                       pend_mem [WORDS];

    logic [AW-1:0] clr_cnt_reg;
    logic          clearing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clearing_reg <= 1'b1;
        end
        else if (clearing_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == AW'(WORDS - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            data_mem[clr_cnt_reg] <= '0;
            pend_mem[clr_cnt_reg] <= 1'b0;
        end
        else
        begin
            if (wr.data_we)
            begin
                data_mem[wr_addr] <= wr_data;
            end
            if (wr.pend_we)
            begin
                pend_mem[wr_addr] <= wr.pend_val;
            end
        end
        rd_data <= data_mem[rd_addr];
        rd_pend <= pend_mem[rd_addr];
    end

    assign busy = clearing_reg;

endmodule

// ===== rtl/core/tsb_regs.sv =====
// Register file with per-register pending marks; out-of-range indices read zero.
module tsb_regs #(
    parameter int COUNT = tsb_pkg::DEF_REGISTER_COUNT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tsb_pkg::regs_ctl_t               ctl,
    input  logic [tsb_pkg::REG_IDX_W-1:0]    wr_idx,
    input  logic [tsb_pkg::DATA_W-1:0]       wr_data,
    input  logic [tsb_pkg::REG_IDX_W-1:0]    pend_idx,
    input  logic [tsb_pkg::REG_IDX_W-1:0]    rd_idx,
    output logic [tsb_pkg::DATA_W-1:0]       rd_data,
    input  logic [tsb_pkg::REG_IDX_W-1:0]    chk_idx,
    output logic                             chk_pend
);

    localparam int RIDX_W = (COUNT > 1) ? $clog2(COUNT) : 1;

    logic [tsb_pkg::DATA_W-1:0] regs_reg [COUNT];
    logic [COUNT-1:0]           pend_reg;

    logic wr_ok;
    logic pend_ok;
    logic rd_ok;
    logic chk_ok;

    assign wr_ok   = 32'(wr_idx)   < COUNT;
    assign pend_ok = 32'(pend_idx) < COUNT;
    assign rd_ok   = 32'(rd_idx)   < COUNT;
    assign chk_ok  = 32'(chk_idx)  < COUNT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < COUNT; i++)
            begin
                regs_reg[i] <= '0;
            end
            pend_reg <= '0;
        end
        else
        begin
            if (ctl.we && wr_ok)
            begin
                regs_reg[RIDX_W'(wr_idx)] <= wr_data;
            end
            if (ctl.pend_set && pend_ok)
            begin
                pend_reg[RIDX_W'(pend_idx)] <= 1'b1;
            end
            else if (ctl.pend_clr && pend_ok)
            begin
                pend_reg[RIDX_W'(pend_idx)] <= 1'b0;
            end
        end
    end

    assign rd_data  = rd_ok ? regs_reg[RIDX_W'(rd_idx)] : '0;
    assign chk_pend = chk_ok && pend_reg[RIDX_W'(chk_idx)];

endmodule
